[hdl/ptb_pkg.sv]
package ptb_pkg;

  localparam int unsigned NUM_CHANNELS = 32;
  localparam int unsigned IDX_W        = $clog2(NUM_CHANNELS);
  localparam int unsigned CH_W         = 5;
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned IN_DATA_W    = 104;
  localparam int unsigned OUT_DATA_W   = 40;

  localparam logic [VAL_W-1:0] RESET_PERIOD = VAL_W'(1000);

  // Request kinds carried on in_tuser
  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_START  = 2'd1;
  localparam logic [1:0] MODE_STOP   = 2'd2;
  localparam logic [1:0] MODE_SETPER = 2'd3;

  typedef struct packed {
    logic [VAL_W-1:0] period;
    logic [VAL_W-1:0] countdown;
    logic [VAL_W-1:0] limit;
    logic [VAL_W-1:0] stage;
  } chan_rec_t;

  localparam chan_rec_t RESET_REC = '{
    period:    RESET_PERIOD,
    countdown: '0,
    limit:     '0,
    stage:     '0
  };

endpackage

[hdl/periodic_timer_bank.sv]
// Channel   Ports                                   Moves
// input     in_tvalid/in_tready/in_tdata/in_tuser   one request: tick, start, stop, set period
// result    out_tvalid/out_tready/out_tdata/out_tlast  one firing: channel and stage
//
// Start, stop and set period read the channel record once; start and set period
// then write it back. A tick scans every channel, reading one channel record per
// cycle from the single-port-read record memory unless the result side stalls
// the scan, then posts the final firing. Reset is synchronous; per-channel
// valid bits stand in for the record reset, so no clearing pass is needed.
// Results leave through an output register, with one firing held back so the
// last firing of a tick can carry out_tlast.
module periodic_timer_bank (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // in_tdata, lowest bit up: channel[4:0], period_ticks[36:5],
  // run_limit_in[68:37], start_stage[100:69], zero fill[103:101]
  input  logic [ptb_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: mode[1:0]
  input  logic [1:0]                     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // out_tdata, lowest bit up: fired_channel[4:0], fired_stage[36:5], zero fill[39:37]
  output logic [ptb_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast
);

  import ptb_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_CMD, ST_SCAN, ST_FLUSH} state_t;

  state_t              st_r;
  logic [IDX_W-1:0]    idx_r;
  logic [1:0]          cmd_mode_r;
  logic [CH_W-1:0]     cmd_ch_r;
  logic [VAL_W-1:0]    cmd_period_r;
  logic [VAL_W-1:0]    cmd_limit_r;
  logic [VAL_W-1:0]    cmd_stage_r;
  logic [NUM_CHANNELS-1:0] running_r;
  logic [NUM_CHANNELS-1:0] valid_r;
  chan_rec_t           rd_data_r;
  logic                pend_valid_r;
  logic [CH_W-1:0]     pend_ch_r;
  logic [VAL_W-1:0]    pend_stage_r;
  logic                out_valid_r;
  logic [CH_W-1:0]     out_ch_r;
  logic [VAL_W-1:0]    out_stage_r;
  logic                out_last_r;

  chan_rec_t           mem [NUM_CHANNELS];

  logic                in_fire;
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  logic                wr_en;
  logic [IDX_W-1:0]    cur_idx;
  chan_rec_t           entry;
  chan_rec_t           rec_nxt;
  logic                cmd_ok;
  logic                run_now;
  logic                expire;
  logic                halt;
  logic                fire_now;
  logic                out_free;
  logic                stall;
  logic                advance;
  logic                last_idx;
  logic                post_now;
  logic [VAL_W-1:0]    start_period;

  assign in_tready  = (st_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - CH_W - VAL_W){1'b0}}, out_stage_r, out_ch_r};
  assign out_tlast  = out_last_r;

  // Pick the record under work; a never-written entry reads as its reset value
  assign cur_idx = (st_r == ST_CMD) ? cmd_ch_r[IDX_W-1:0] : idx_r;
  assign entry   = valid_r[cur_idx] ? rd_data_r : RESET_REC;
  assign cmd_ok  = (32'(cmd_ch_r) < NUM_CHANNELS);

  // Decide the fate of the scanned channel
  assign run_now  = running_r[idx_r];
  assign expire   = (entry.countdown <= VAL_W'(1));
  assign halt     = (entry.limit != '0) && (entry.stage >= entry.limit);
  assign fire_now = run_now && expire && !halt;
  assign out_free = !out_valid_r || out_tready;
  assign stall    = (st_r == ST_SCAN) && fire_now && pend_valid_r && !out_free;
  assign advance  = (st_r == ST_SCAN) && !stall;
  assign last_idx = (idx_r == IDX_W'(NUM_CHANNELS - 1));

  // Load the output register this cycle, either mid-scan or at flush
  assign post_now = (advance && fire_now && pend_valid_r) ||
                    ((st_r == ST_FLUSH) && pend_valid_r && out_free);

  // Issue reads: the addressed channel for a command, channel zero then the next for a tick
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_r + IDX_W'(1);
    if (in_fire) begin
      rd_en   = 1'b1;
      rd_addr = (in_tuser == MODE_TICK) ? '0 : in_tdata[IDX_W-1:0];
    end else if (advance && !last_idx) begin
      rd_en = 1'b1;
    end
  end

  // Build the write-back record
  assign start_period = (cmd_period_r != '0) ? cmd_period_r :
                        ((entry.period == '0) ? VAL_W'(1) : entry.period);

  always_comb begin
    rec_nxt = entry;
    wr_en   = 1'b0;
    case (st_r)
      ST_CMD: begin
        if (cmd_ok && cmd_mode_r == MODE_START) begin
          wr_en             = 1'b1;
          rec_nxt.period    = start_period;
          rec_nxt.countdown = start_period;
          rec_nxt.limit     = cmd_limit_r;
          rec_nxt.stage     = cmd_stage_r;
        end else if (cmd_ok && cmd_mode_r == MODE_SETPER) begin
          wr_en          = 1'b1;
          rec_nxt.period = (cmd_period_r == '0) ? VAL_W'(1) : cmd_period_r;
        end
      end
      ST_SCAN: begin
        if (advance && run_now) begin
          wr_en = 1'b1;
          if (!expire) begin
            rec_nxt.countdown = entry.countdown - VAL_W'(1);
          end else if (halt) begin
            rec_nxt.countdown = '0;
          end else begin
            rec_nxt.countdown = entry.period;
            rec_nxt.stage     = entry.stage + VAL_W'(1);
          end
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Record memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cur_idx] <= rec_nxt;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Sequencer, channel flags and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      idx_r        <= '0;
      running_r    <= '0;
      valid_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // drain the output register
      if (out_valid_r && out_tready && !post_now) begin
        out_valid_r <= 1'b0;
      end
      if (wr_en) begin
        valid_r[cur_idx] <= 1'b1;
      end
      case (st_r)
        ST_IDLE: begin
          if (in_fire) begin
            cmd_mode_r   <= in_tuser;
            cmd_ch_r     <= in_tdata[CH_W-1:0];
            cmd_period_r <= in_tdata[CH_W+VAL_W-1:CH_W];
            cmd_limit_r  <= in_tdata[CH_W+2*VAL_W-1:CH_W+VAL_W];
            cmd_stage_r  <= in_tdata[CH_W+3*VAL_W-1:CH_W+2*VAL_W];
            idx_r        <= '0;
            st_r         <= (in_tuser == MODE_TICK) ? ST_SCAN : ST_CMD;
          end
        end
        ST_CMD: begin
          if (cmd_ok && cmd_mode_r == MODE_START) begin
            running_r[cmd_ch_r[IDX_W-1:0]] <= 1'b1;
          end else if (cmd_ok && cmd_mode_r == MODE_STOP) begin
            running_r[cmd_ch_r[IDX_W-1:0]] <= 1'b0;
          end
          st_r <= ST_IDLE;
        end
        ST_SCAN: begin
          if (advance) begin
            if (run_now && expire && halt) begin
              running_r[idx_r] <= 1'b0;
            end
            // hold the new firing back, post the previous one
            if (fire_now) begin
              if (pend_valid_r) begin
                out_valid_r <= 1'b1;
                out_ch_r    <= pend_ch_r;
                out_stage_r <= pend_stage_r;
                out_last_r  <= 1'b0;
              end
              pend_valid_r <= 1'b1;
              pend_ch_r    <= CH_W'(idx_r);
              pend_stage_r <= entry.stage;
            end
            if (last_idx) begin
              st_r <= ST_FLUSH;
            end else begin
              idx_r <= idx_r + IDX_W'(1);
            end
          end
        end
        ST_FLUSH: begin
          // post the final firing of the tick with tlast
          if (!pend_valid_r) begin
            st_r <= ST_IDLE;
          end else if (out_free) begin
            out_valid_r  <= 1'b1;
            out_ch_r     <= pend_ch_r;
            out_stage_r  <= pend_stage_r;
            out_last_r   <= 1'b1;
            pend_valid_r <= 1'b0;
            st_r         <= ST_IDLE;
          end
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
    end
  end

  // No firing may be held back while new requests are taken
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !pend_valid_r)
    else $error("held firing left over at idle");

  // The scan never writes the entry it is reading ahead
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (cur_idx != rd_addr))
    else $error("read and write address collide");

  // A second firing pushes the held one into the output register
  a_push_out: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && fire_now && pend_valid_r) |=> (out_tvalid && !out_tlast))
    else $error("held firing not posted");

  // The final firing of a tick always carries tlast
  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_FLUSH && pend_valid_r && out_free) |=> (out_tvalid && out_tlast))
    else $error("final firing lacks tlast");

endmodule

[test/tb_periodic_timer_bank.sv]
module tb_periodic_timer_bank;
  import ptb_pkg::*;

  localparam int RANDOM_REQUESTS = 350;
  localparam int CYCLE_LIMIT     = 1500000;
  // a tick scans every channel; allow that twice over before calling the bank quiet
  localparam int SETTLE_CYCLES   = 2 * NUM_CHANNELS + 8;
  localparam int LONG_HOLD       = 400;
  localparam int HOLD_AFTER      = 60;

  typedef struct {
    logic [CH_W-1:0]  channel;
    logic [VAL_W-1:0] stage;
    logic             last;
  } firing_t;

  // Mirror of the timer bank: per-channel state and the firings still owed
  class timer_scoreboard;
    bit               running   [NUM_CHANNELS];
    logic [VAL_W-1:0] period    [NUM_CHANNELS];
    logic [VAL_W-1:0] countdown [NUM_CHANNELS];
    logic [VAL_W-1:0] limit     [NUM_CHANNELS];
    logic [VAL_W-1:0] stage     [NUM_CHANNELS];
    firing_t          fires_due [$];
    int               errors;

    function new();
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        running[i]   = 1'b0;
        period[i]    = RESET_PERIOD;
        countdown[i] = '0;
        limit[i]     = '0;
        stage[i]     = '0;
      end
      errors = 0;
    endfunction

    // Apply one accepted request and queue the firings a tick causes
    function void note_request(logic [1:0] mode, logic [CH_W-1:0] ch,
                               logic [VAL_W-1:0] new_period,
                               logic [VAL_W-1:0] new_limit,
                               logic [VAL_W-1:0] new_stage);
      firing_t burst [$];
      firing_t f;
      case (mode)
        MODE_START: begin
          if (new_period != '0) period[ch] = new_period;
          if (period[ch] == '0) period[ch] = 1;
          countdown[ch] = period[ch];
          limit[ch]     = new_limit;
          stage[ch]     = new_stage;
          running[ch]   = 1'b1;
        end
        MODE_STOP: begin
          running[ch] = 1'b0;
        end
        MODE_SETPER: begin
          period[ch] = (new_period == '0) ? VAL_W'(1) : new_period;
        end
        default: begin
          // tick: count down, expire in ascending channel order
          for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (!running[i]) continue;
            if (countdown[i] > 1) begin
              countdown[i] = countdown[i] - 1;
              continue;
            end
            countdown[i] = '0;
            if (limit[i] != '0 && stage[i] >= limit[i]) begin
              running[i] = 1'b0;
              continue;
            end
            f.channel = CH_W'(i);
            f.stage   = stage[i];
            f.last    = 1'b0;
            burst.push_back(f);
            stage[i]     = stage[i] + 1;
            countdown[i] = period[i];
          end
          if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
          foreach (burst[j]) fires_due.push_back(burst[j]);
        end
      endcase
    endfunction

    // Compare one accepted firing with the oldest one owed
    function void check_firing(logic [CH_W-1:0] ch, logic [VAL_W-1:0] stg, logic lst);
      firing_t want;
      if (fires_due.size() == 0) begin
        $error("unexpected firing: fired_channel %0d fired_stage %0d", ch, stg);
        errors++;
        return;
      end
      want = fires_due.pop_front();
      if (ch !== want.channel) begin
        $error("fired_channel: expected %0d, got %0d", want.channel, ch);
        errors++;
      end
      if (stg !== want.stage) begin
        $error("fired_stage: expected 0x%08h, got 0x%08h", want.stage, stg);
        errors++;
      end
      if (lst !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, lst);
        errors++;
      end
    endfunction

    function int outstanding();
      return fires_due.size();
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata  = '0;
  logic [1:0]            in_tuser  = MODE_TICK;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  int unsigned           cycle_count = 0;

  timer_scoreboard sb = new();

  periodic_timer_bank dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_periodic_timer_bank NOT OK");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one request and hold it until the bank takes it
  task automatic send_request(input logic [1:0] mode, input logic [CH_W-1:0] ch,
                              input logic [VAL_W-1:0] period,
                              input logic [VAL_W-1:0] limit,
                              input logic [VAL_W-1:0] stage,
                              input bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {3'b000, stage, limit, period, ch};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(mode, ch, period, limit, stage);
  endtask

  // Drop valid and wait for every owed firing, then for SETTLE_CYCLES more
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result side: check firings, stall at random, one long hold-off
  initial begin : result_sink
    int hold_left;
    int stall_left;
    int seen;
    int cyc;
    hold_left  = 0;
    stall_left = 0;
    seen       = 0;
    cyc        = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (rst_n && out_tvalid && out_tready) begin
        sb.check_firing(out_tdata[CH_W-1:0], out_tdata[CH_W +: VAL_W], out_tlast);
        seen++;
        if (seen == HOLD_AFTER) hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if ((cyc / 256) % 4 == 1) begin
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    int               r;
    logic [1:0]       mode;
    logic [CH_W-1:0]  ch;
    logic [VAL_W-1:0] period;
    logic [VAL_W-1:0] limit;
    logic [VAL_W-1:0] stage;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // tick with nothing running
    send_request(MODE_TICK, 5'd0, '0, '0, '0);
    // clamp a zero period, then start keeping it; stop silently at the limit
    send_request(MODE_SETPER, 5'd31, '0, '0, '0);
    send_request(MODE_START, 5'd31, '0, 32'd2, '0);
    // stage wraps at 32 bits
    send_request(MODE_START, 5'd0, 32'd1, '0, 32'hFFFF_FFFF);
    // largest limit reached just below the wrap
    send_request(MODE_START, 5'd5, 32'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    // largest period never expires here
    send_request(MODE_START, 5'd7, 32'hFFFF_FFFF, '0, '0);
    // stage already past the limit: stop at first expiry, no firing
    send_request(MODE_START, 5'd9, 32'd1, 32'd3, 32'd7);
    // zero period at start keeps the reset period
    send_request(MODE_START, 5'd20, '0, '0, 32'h1234_5678);
    // stop of a stopped channel
    send_request(MODE_STOP, 5'd12, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(MODE_TICK, 5'd31, '0, '0, '0);
    send_request(MODE_TICK, 5'd0, '0, '0, '0);
    // restart a running channel; change a running channel's period
    send_request(MODE_START, 5'd7, 32'd3, '0, 32'd100);
    send_request(MODE_SETPER, 5'd5, 32'd3, '0, '0);
    repeat (3) send_request(MODE_TICK, 5'd0, '0, '0, '0);
    send_request(MODE_STOP, 5'd0, '0, '0, '0);
    send_request(MODE_STOP, 5'd0, '0, '0, '0);
    repeat (3) send_request(MODE_TICK, 5'd0, '0, '0, '0);

    // Random requests: small periods so channels fire often
    for (int k = 0; k < RANDOM_REQUESTS; k++) begin
      if (k == RANDOM_REQUESTS / 2) wait_quiet();
      r = $urandom_range(0, 99);
      mode = (r < 45) ? MODE_TICK : (r < 72) ? MODE_START : (r < 82) ? MODE_STOP : MODE_SETPER;
      ch = CH_W'($urandom_range(0, NUM_CHANNELS - 1));
      r = $urandom_range(0, 99);
      period = (r < 70) ? VAL_W'($urandom_range(1, 6)) :
               (r < 80) ? '0 :
               (r < 90) ? VAL_W'($urandom_range(7, 40)) : VAL_W'($urandom());
      r = $urandom_range(0, 99);
      limit = (r < 50) ? '0 : (r < 85) ? VAL_W'($urandom_range(1, 20)) : VAL_W'($urandom());
      r = $urandom_range(0, 99);
      stage = (r < 60) ? VAL_W'($urandom_range(0, 10)) :
              (r < 80) ? (32'hFFFF_FFF0 | VAL_W'($urandom_range(0, 15))) : VAL_W'($urandom());
      send_request(mode, ch, period, limit, stage, (k / 50) % 4 == 3);
    end

    wait_quiet();
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb_periodic_timer_bank OK");
    end else begin
      if (sb.outstanding() != 0) $error("%0d firings never arrived", sb.outstanding());
      $display("tb_periodic_timer_bank NOT OK");
    end
    $finish;
  end

endmodule
